/* sv/cmfa_pkg.sv */
// ----------------------------------------------------------------------------
// cmfa_pkg: shared types and constants of the chunk map allocator
// Holds field widths, chunk mark codes, register indexes and the control
// struct that drives the run unit.
// ----------------------------------------------------------------------------
package cmfa_pkg;

  localparam int unsigned REQ_W      = 21;
  localparam int unsigned CB_W       = 13;
  localparam int unsigned UB_W       = 21;
  localparam int unsigned COV_W      = 22;
  localparam int unsigned PAGE_NUM_W = 3;
  localparam int unsigned START_W    = 8;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned MARK_W     = 2;

  localparam logic [CB_W-1:0] CHUNK_BYTES_RST       = CB_W'(16);
  localparam logic [UB_W-1:0] PAGE_USABLE_BYTES_RST = UB_W'(4096);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_USABLE_BYTES = CFG_IDX_W'(1);

  // Chunk mark codes
  localparam logic [MARK_W-1:0] MARK_FREE = 2'd0;
  localparam logic [MARK_W-1:0] MARK_BODY = 2'd1;
  localparam logic [MARK_W-1:0] MARK_LAST = 2'd2;

  typedef struct packed {
    logic clear;  // restart the run at chunk zero
    logic step;   // one mark arrives
    logic free;   // that mark is free
  } run_ctl_t;

endpackage

/* sv/cmfa_if.sv */
// ----------------------------------------------------------------------------
// cmfa interfaces: request, response and configuration channels
// Each channel is a valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface cmfa_req_if import cmfa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] request_bytes;

  modport source (output valid, output request_bytes, input ready);
  modport sink   (input valid, input request_bytes, output ready);
endinterface

interface cmfa_rsp_if import cmfa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  granted;
  logic [PAGE_NUM_W-1:0] page_number;
  logic [START_W-1:0]    start_chunk;
  logic                  opened_page;

  modport source (output valid, output granted, output page_number,
                  output start_chunk, output opened_page, input ready);
  modport sink   (input valid, input granted, input page_number,
                  input start_chunk, input opened_page, output ready);
endinterface

interface cmfa_cfg_if import cmfa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/cmfa_mark_mem.sv */
// ----------------------------------------------------------------------------
// cmfa_mark_mem: chunk mark memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cmfa_mark_mem import cmfa_pkg::*; #(
  parameter int unsigned AW = 11
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [MARK_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [MARK_W-1:0] rdata_o
);

  logic [MARK_W-1:0] mem_q [2**AW];
  logic [MARK_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/cmfa_run_unit.sv */
// ----------------------------------------------------------------------------
// cmfa_run_unit: shared run accumulator
// Sums the bytes of the current free run one mark at a time and flags the
// first mark at which the run covers the request.
// ----------------------------------------------------------------------------
module cmfa_run_unit import cmfa_pkg::*; #(
  parameter int unsigned CIDX_W = 8,
  parameter int unsigned CNT_W  = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  run_ctl_t          ctl_i,
  input  logic [CIDX_W-1:0] idx_i,
  input  logic [CB_W-1:0]   chunk_bytes_i,
  input  logic [REQ_W-1:0]  need_i,
  output logic              hit_o,
  output logic [CNT_W-1:0]  start_o
);

  logic [COV_W-1:0] cov_q, cov_d, sum;
  logic [CNT_W-1:0] start_q, start_d;

  assign sum   = cov_q + COV_W'(chunk_bytes_i);
  assign hit_o = ctl_i.step && ctl_i.free && (sum >= COV_W'(need_i));
  assign start_o = start_q;

  always_comb begin
    cov_d   = cov_q;
    start_d = start_q;
    if (ctl_i.clear) begin
      cov_d   = '0;
      start_d = '0;
    end else if (ctl_i.step) begin
      if (ctl_i.free) begin
        cov_d = sum;
      end else begin
        // busy mark: the next run can start one chunk later
        cov_d   = '0;
        start_d = CNT_W'(idx_i) + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cov_q   <= '0;
      start_q <= '0;
    end else begin
      cov_q   <= cov_d;
      start_q <= start_d;
    end
  end

endmodule

/* sv/chunk_map_first_fit_allocator_core.sv */
// ----------------------------------------------------------------------------
// chunk_map_first_fit_allocator_core: first-fit chunk allocator, one class
// Serves allocation requests from up to PAGES pages of CHUNKS chunk marks.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_if : register writes (index 0 chunk_bytes, 1 page_usable_bytes),
//            always ready; write only while no request is in flight.
//   req_if : one request_bytes per request; ready only when the sequencer
//            is idle, so a single request is in work at a time.
//   rsp_if : one result per request, held in an output register; the next
//            request is taken while that result still waits for ready.
// Steps: check the size, then scan each open page (newest first, one mark
//   read per cycle through the shared run unit) with a step to move on to
//   the next page, clear a newly opened page before its scan, mark each
//   chunk of the granted run, and post the result. The scan is bounded by
//   the single read port of the mark memory.
// Reset: no pages open, registers at 16 and 4096. The memory is not cleared
//   at reset; each page is cleared as it is opened.
// A stalled receiver holds the result; the block finishes the next request
//   and then waits for the output register to drain.
// ----------------------------------------------------------------------------
module chunk_map_first_fit_allocator_core import cmfa_pkg::*; #(
  parameter int unsigned CHUNKS = 256,
  parameter int unsigned PAGES  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cmfa_cfg_if.sink    cfg_if,
  cmfa_req_if.sink    req_if,
  cmfa_rsp_if.source  rsp_if
);

  localparam int unsigned CIDX_W = $clog2(CHUNKS);
  localparam int unsigned CNT_W  = $clog2(CHUNKS + 1);
  localparam int unsigned PIDX_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned PCNT_W = $clog2(PAGES + 1);
  localparam int unsigned AW     = PIDX_W + CIDX_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_OPEN, ST_CLEAR, ST_SCAN, ST_NEXT, ST_MARK, ST_DONE
  } state_e;

  state_e state_q, state_d;

  logic [CB_W-1:0]   chunk_bytes_q;
  logic [UB_W-1:0]   usable_q;
  logic [PCNT_W-1:0] pcnt_q, pcnt_d, pcnt_m1;
  logic [PIDX_W-1:0] page_q, page_d;
  logic              opened_q, opened_d;
  logic              granted_q, granted_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [CIDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic [REQ_W-1:0]  need_q, need_d;
  logic [CIDX_W-1:0] widx_q, widx_d;
  logic [CIDX_W-1:0] last_q, last_d;
  logic [CIDX_W-1:0] res_start_q, res_start_d;

  logic                  out_valid_q, out_valid_d;
  logic                  out_granted_q, out_granted_d;
  logic [PAGE_NUM_W-1:0] out_page_q, out_page_d;
  logic [START_W-1:0]    out_start_q, out_start_d;
  logic                  out_opened_q, out_opened_d;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [MARK_W-1:0] mem_wdata, mem_rdata;

  run_ctl_t          run_ctl;
  logic              run_hit;
  logic [CNT_W-1:0]  run_start;

  logic [PIDX_W+PAGE_NUM_W-1:0] page_ext;
  logic [CIDX_W+START_W-1:0]    start_ext;

  // Configuration registers
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_bytes_q <= CHUNK_BYTES_RST;
      usable_q      <= PAGE_USABLE_BYTES_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_CHUNK_BYTES:       chunk_bytes_q <= cfg_if.data[CB_W-1:0];
        CFG_PAGE_USABLE_BYTES: usable_q      <= cfg_if.data[UB_W-1:0];
        default: ;
      endcase
    end
  end

  cmfa_mark_mem #(.AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign run_ctl.clear = (state_q != ST_SCAN);
  assign run_ctl.step  = (state_q == ST_SCAN) && cmp_vld_q;
  assign run_ctl.free  = (mem_rdata == MARK_FREE);

  cmfa_run_unit #(.CIDX_W(CIDX_W), .CNT_W(CNT_W)) u_run (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (run_ctl),
    .idx_i         (cmp_idx_q),
    .chunk_bytes_i (chunk_bytes_q),
    .need_i        (need_q),
    .hit_o         (run_hit),
    .start_o       (run_start)
  );

  assign pcnt_m1   = pcnt_q - PCNT_W'(1);
  assign mem_re    = (state_q == ST_SCAN) && (rd_idx_q != CNT_W'(CHUNKS));
  assign mem_raddr = {page_q, rd_idx_q[CIDX_W-1:0]};
  assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_MARK);
  assign mem_waddr = {page_q, widx_q};
  assign mem_wdata = (state_q == ST_CLEAR) ? MARK_FREE :
                     (widx_q == last_q)    ? MARK_LAST : MARK_BODY;

  assign page_ext  = {{PAGE_NUM_W{1'b0}}, page_q};
  assign start_ext = {{START_W{1'b0}}, res_start_q};

  assign req_if.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    pcnt_d        = pcnt_q;
    page_d        = page_q;
    opened_d      = opened_q;
    granted_d     = granted_q;
    rd_idx_d      = '0;
    cmp_vld_d     = 1'b0;
    cmp_idx_d     = cmp_idx_q;
    need_d        = need_q;
    widx_d        = widx_q;
    last_d        = last_q;
    res_start_d   = res_start_q;
    out_valid_d   = out_valid_q && !rsp_if.ready;
    out_granted_d = out_granted_q;
    out_page_d    = out_page_q;
    out_start_d   = out_start_q;
    out_opened_d  = out_opened_q;

    case (state_q)
      ST_IDLE: begin
        if (req_if.valid) begin
          need_d    = (req_if.request_bytes == '0) ? REQ_W'(1) : req_if.request_bytes;
          opened_d  = 1'b0;
          granted_d = 1'b0;
          state_d   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (need_q > usable_q) begin
          state_d = ST_DONE;
        end else if (pcnt_q != '0) begin
          page_d  = pcnt_m1[PIDX_W-1:0];
          state_d = ST_SCAN;
        end else begin
          state_d = ST_OPEN;
        end
      end
      ST_OPEN: begin
        if (pcnt_q != PCNT_W'(PAGES)) begin
          page_d   = pcnt_q[PIDX_W-1:0];
          pcnt_d   = pcnt_q + PCNT_W'(1);
          opened_d = 1'b1;
          widx_d   = '0;
          state_d  = ST_CLEAR;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CLEAR: begin
        widx_d = widx_q + CIDX_W'(1);
        if (widx_q == CIDX_W'(CHUNKS - 1)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue one read per cycle; compare the data in the next cycle
        rd_idx_d  = mem_re ? rd_idx_q + CNT_W'(1) : rd_idx_q;
        cmp_vld_d = mem_re;
        cmp_idx_d = rd_idx_q[CIDX_W-1:0];
        if (run_hit) begin
          res_start_d = run_start[CIDX_W-1:0];
          widx_d      = run_start[CIDX_W-1:0];
          last_d      = cmp_idx_q;
          state_d     = ST_MARK;
        end else if (cmp_vld_q && (cmp_idx_q == CIDX_W'(CHUNKS - 1))) begin
          if (opened_q) begin
            state_d = ST_DONE;
          end else if (page_q == '0) begin
            state_d = ST_OPEN;
          end else begin
            page_d  = page_q - PIDX_W'(1);
            state_d = ST_NEXT;
          end
        end
      end
      ST_NEXT: begin
        state_d = ST_SCAN;
      end
      ST_MARK: begin
        widx_d = widx_q + CIDX_W'(1);
        if (widx_q == last_q) begin
          granted_d = 1'b1;
          state_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || rsp_if.ready) begin
          out_valid_d   = 1'b1;
          out_granted_d = granted_q;
          out_page_d    = granted_q ? page_ext[PAGE_NUM_W-1:0] : '0;
          out_start_d   = granted_q ? start_ext[START_W-1:0] : '0;
          out_opened_d  = opened_q;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pcnt_q      <= '0;
      page_q      <= '0;
      opened_q    <= 1'b0;
      granted_q   <= 1'b0;
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pcnt_q      <= pcnt_d;
      page_q      <= page_d;
      opened_q    <= opened_d;
      granted_q   <= granted_d;
      rd_idx_q    <= rd_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q     <= cmp_idx_d;
    need_q        <= need_d;
    widx_q        <= widx_d;
    last_q        <= last_d;
    res_start_q   <= res_start_d;
    out_granted_q <= out_granted_d;
    out_page_q    <= out_page_d;
    out_start_q   <= out_start_d;
    out_opened_q  <= out_opened_d;
  end

  assign rsp_if.valid       = out_valid_q;
  assign rsp_if.granted     = out_granted_q;
  assign rsp_if.page_number = out_page_q;
  assign rsp_if.start_chunk = out_start_q;
  assign rsp_if.opened_page = out_opened_q;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_if.valid && req_if.ready |=> !req_if.ready)
    else $error("request accepted while another is in work");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_if.valid && !rsp_if.granted |->
      (rsp_if.page_number == '0) && (rsp_if.start_chunk == '0))
    else $error("failed response carries a page or chunk");

  a_pcnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcnt_q != $past(pcnt_q) |->
      (pcnt_q == PCNT_W'($past(pcnt_q) + PCNT_W'(1))) && opened_q)
    else $error("open page count moved without opening a page");

  a_opened_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_if.valid && rsp_if.opened_page |-> pcnt_q != '0)
    else $error("response reports an opened page but none is open");

endmodule
